[rtl/avgpu_pkg.sv]
// ----------------------------------------------------------------------------
// avgpu_pkg
// Shared types and constants of the average predictor unfilter: register
// indexes, the position flags carried with a request, and the predictor.
// ----------------------------------------------------------------------------
package avgpu_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

  localparam logic [12:0] WIDTH_RESET    = 13'd1;
  localparam logic [15:0] HEIGHT_RESET   = 16'd1;
  localparam logic [2:0]  CHANNELS_RESET = 3'd4;

  // where the request sits in the frame, decided at accept time
  typedef struct packed {
    logic row_first;
    logic col_first;
    logic frame_end;
  } avgpu_pos_t;

  function automatic logic [7:0] avg_predict(input avgpu_pos_t pos,
                                             input logic [7:0] left,
                                             input logic [7:0] above);
    logic [8:0] sum;
    sum = {1'b0, left} + {1'b0, above};
    if (pos.row_first && pos.col_first) begin
      avg_predict = 8'd0;
    end else if (pos.row_first) begin
      avg_predict = left;
    end else if (pos.col_first) begin
      avg_predict = above;
    end else begin
      avg_predict = sum[8:1];
    end
  endfunction

endpackage

[rtl/average_predictor_unfilter.sv]
// ----------------------------------------------------------------------------
// average_predictor_unfilter
// Rebuilds pixel bytes from average-filtered residuals with a line store.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_residual/in_stall carries one residual byte per request, in
//   raster order with the channels of a pixel interleaved. out_valid/
//   out_pixel_byte/out_frame_end returns one reconstructed byte per request,
//   out_frame_end marking the last byte of the frame. The cfg_ port writes
//   image_width, image_height and channel_count (cfg_ready is always high);
//   write it only while no request is in flight.
//   A request goes through the compute stage and the output register to
//   out_valid. Throughput: one byte per cycle unless the receiver stalls,
//   set by the single line-store read at accept and its write-back at
//   retire; a byte that meets its own entry back to back takes the forwarded value.
//   When the receiver stalls, the result holds in the output register and
//   one more request may sit in the compute stage; after that in_stall rises.
//   Reset clears the position and the pipeline and loads width 1, height 1
//   and four channels. The line store is not cleared: the first row reads it
//   but never uses the value, and each later row reads only what the row before wrote.
// ----------------------------------------------------------------------------
module average_predictor_unfilter #(
  parameter int MAX_WIDTH    = 4096,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [7:0]                        in_residual,
  output logic                              in_stall,
  output logic                              out_valid,
  output logic [7:0]                        out_pixel_byte,
  output logic                              out_frame_end,
  input  logic                              out_stall,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [avgpu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [avgpu_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import avgpu_pkg::*;

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int CCNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [12:0] image_width_r;
  logic [15:0] image_height_r;
  logic [2:0]  channel_count_r;

  // position of the next request
  logic [CH_W-1:0]  ch_r,  ch_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [15:0]      row_r, row_nxt;

  // compute stage
  logic              s1_valid_r;
  logic [7:0]        s1_residual_r;
  avgpu_pos_t        s1_pos_r;
  logic [CH_W-1:0]   s1_ch_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic              fwd_r;
  logic [7:0]        fwd_data_r;

  // output register
  logic       out_valid_r;
  logic [7:0] out_pixel_r;
  logic       out_frame_end_r;

  logic [7:0] row_store [DEPTH];
  logic [7:0] rd_data_r;
  logic [7:0] left_r [MAX_CHANNELS];

  logic [WCNT_W-1:0] w_eff;
  logic [15:0]       h_eff;
  logic [CCNT_W-1:0] ch_eff;
  logic              last_ch, last_col, last_row;
  logic              in_accept, s1_adv;
  logic [ADDR_W-1:0] in_addr;
  avgpu_pos_t        in_pos;
  logic [7:0]        above, left, s1_pix;

  assign cfg_ready = 1'b1;

  // clamp the configured sizes to what the store holds
  always_comb begin
    if (image_width_r == 13'd0) begin
      w_eff = WCNT_W'(1);
    end else if (32'(image_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WCNT_W'(MAX_WIDTH);
    end else begin
      w_eff = WCNT_W'(image_width_r);
    end
    h_eff = (image_height_r == 16'd0) ? 16'd1 : image_height_r;
    if (channel_count_r == 3'd0) begin
      ch_eff = CCNT_W'(1);
    end else if (32'(channel_count_r) > 32'(MAX_CHANNELS)) begin
      ch_eff = CCNT_W'(MAX_CHANNELS);
    end else begin
      ch_eff = CCNT_W'(channel_count_r);
    end
  end

  assign s1_adv    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  assign last_ch  = (32'(ch_r) + 32'd1) >= 32'(ch_eff);
  assign last_col = (32'(col_r) + 32'd1) >= 32'(w_eff);
  assign last_row = (32'(row_r) + 32'd1) >= 32'(h_eff);

  assign in_addr          = ADDR_W'(32'(col_r) * MAX_CHANNELS + 32'(ch_r));
  assign in_pos.row_first = (row_r == 16'd0);
  assign in_pos.col_first = (col_r == '0);
  assign in_pos.frame_end = last_ch && last_col && last_row;

  always_comb begin
    ch_nxt  = ch_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (!last_ch) begin
      ch_nxt = CH_W'(ch_r + 1'b1);
    end else begin
      ch_nxt = '0;
      if (!last_col) begin
        col_nxt = COL_W'(col_r + 1'b1);
      end else begin
        col_nxt = '0;
        row_nxt = last_row ? 16'd0 : 16'(row_r + 16'd1);
      end
    end
  end

  // take the previous byte straight from the write-back when it hit the same entry
  assign above  = fwd_r ? fwd_data_r : rd_data_r;
  assign left   = left_r[s1_ch_r];
  assign s1_pix = 8'(s1_residual_r + avg_predict(s1_pos_r, left, above));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= WIDTH_RESET;
      image_height_r  <= HEIGHT_RESET;
      channel_count_r <= CHANNELS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:   image_width_r   <= cfg_data[12:0];
        CFG_IMAGE_HEIGHT:  image_height_r  <= cfg_data[15:0];
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r        <= '0;
      col_r       <= '0;
      row_r       <= 16'd0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      if (in_accept) begin
        ch_r  <= ch_nxt;
        col_r <= col_nxt;
        row_r <= row_nxt;
        fwd_r <= s1_adv && (s1_addr_r == in_addr);
      end else if (s1_adv) begin
        // drop the forward flag once the stage drains
        fwd_r <= 1'b0;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload of the pipeline
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_residual_r <= in_residual;
      s1_pos_r      <= in_pos;
      s1_ch_r       <= ch_r;
      s1_addr_r     <= in_addr;
    end
    if (s1_adv) begin
      out_pixel_r     <= s1_pix;
      out_frame_end_r <= s1_pos_r.frame_end;
      fwd_data_r      <= s1_pix;
      left_r[s1_ch_r] <= s1_pix;
    end
  end

  // line store: read at accept, write back when the byte retires
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_data_r <= row_store[in_addr];
    end
    if (s1_adv) begin
      row_store[s1_addr_r] <= s1_pix;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_byte = out_pixel_r;
  assign out_frame_end  = out_frame_end_r;

  // a forwarded value only exists for a byte in the compute stage
  a_fwd_in_stage: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("forward flag without a byte in the compute stage");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted request did not reach the compute stage");

  a_retire_shows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("retired byte did not reach the output register");

endmodule
